// ----- hdl/slk_pkg.sv -----
// shared types and constants for the spike key row address lookup
// no dependencies; used by spike_key_row_address_lookup
package slk_pkg;

    localparam int SLK_TABLE_DEPTH  = 1152;
    localparam int SLK_HEADER_WORDS = 3;
    localparam int SLK_NUM_REGS     = 8;
    localparam int SLK_CFG_IDX_W    = 3;
    localparam int SLK_CFG_DATA_W   = 32;

    // configuration register indexes
    localparam logic [SLK_CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 3'd0;

    // result status codes
    localparam logic [1:0] ST_HIT    = 2'd0;
    localparam logic [1:0] ST_MISS   = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;
    localparam logic [1:0] ST_LOADED = 2'd3;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [31:0] spike_key;
        logic [10:0] load_index;
        logic [15:0] load_entry;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] tbl_pos;
        logic [31:0] row_addr;
        logic [18:0] transfer_bytes;
        logic [31:0] miss_count;
    } t_rsp;

endpackage

// ----- hdl/spike_key_row_address_lookup.sv -----
// spike key row address lookup, top level
// depends on slk_pkg and slk_ram
//
// usage:
//   request channel i_valid / o_stall / i_req: a lookup (cmd 0) splits the
//   spike key into x, y, p and neuron, reads the population table entry at
//   (x*8+y)*18+p and returns the row address and transfer size; a load
//   (cmd 1) writes one table entry. one result per request.
//   result channel o_valid / i_stall / o_rsp carries status, table index,
//   row address, transfer bytes and the miss count after the request.
//   configuration: i_cfg_we writes i_cfg_data to register i_cfg_index (0 base address,
//   1..7 row words); the user must write only while the block is idle (not enforced).
// table ram read, stride multiply and address add are each registered before
//   o_valid rises. throughput: one request per cycle unless a held result stalls,
//   set by the single table ram read port and the one neuron-by-stride multiplier.
// reset: synchronous active low; clears the pipeline, miss counter and the
//   configuration registers. the table is not cleared: a lookup must only
//   hit entries that have been loaded.
// stall: a held result freezes the whole pipeline, the ram read data is
//   held, and o_stall goes high towards the sender.
module spike_key_row_address_lookup #(
    parameter int TABLE_DEPTH  = slk_pkg::SLK_TABLE_DEPTH,
    parameter int HEADER_WORDS = slk_pkg::SLK_HEADER_WORDS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  slk_pkg::t_req                       i_req,
    output logic                                o_valid,
    input  logic                                i_stall,
    output slk_pkg::t_rsp                       o_rsp,
    input  logic                                i_cfg_we,
    input  logic [slk_pkg::SLK_CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [slk_pkg::SLK_CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [16:0] DEPTH_LIM = 17'(TABLE_DEPTH);
    localparam logic [16:0] HDR       = 17'(HEADER_WORDS);

    // configuration registers
    logic [31:0] r_base;
    logic [15:0] r_row_words [1:slk_pkg::SLK_NUM_REGS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            for (int i = 1; i < slk_pkg::SLK_NUM_REGS; i++) begin
                r_row_words[i] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == slk_pkg::CFG_BASE_ADDRESS) begin
                r_base <= i_cfg_data;
            end else begin
                r_row_words[i_cfg_index] <= i_cfg_data[15:0];
            end
        end
    end

    // pipeline enable: everything moves when the output slot is free or taken
    logic en;
    logic r_out_valid;
    assign en      = !r_out_valid || !i_stall;
    assign o_stall = !en;

    logic accept;
    assign accept = i_valid && en;

    // stage a: table position and ram access
    logic [11:0] xy;
    logic [15:0] lk_pos;
    logic [15:0] ld_pos;
    logic        lk_bad;
    logic        ld_bad;
    logic        ram_we;
    logic        ram_re;
    logic [15:0] ram_entry;

    assign xy     = {1'b0, i_req.spike_key[31:24], 3'b000} + {4'b0, i_req.spike_key[23:16]};
    // times 18 as x16 plus x2
    assign lk_pos = {xy, 4'b0000} + {3'b000, xy, 1'b0} + {11'b0, i_req.spike_key[15:11]};
    assign ld_pos = {5'b0, i_req.load_index};
    assign lk_bad = {1'b0, lk_pos} >= DEPTH_LIM;
    assign ld_bad = {1'b0, ld_pos} >= DEPTH_LIM;
    assign ram_we = accept && (i_req.cmd == slk_pkg::CMD_LOAD) && !ld_bad;
    assign ram_re = accept && (i_req.cmd == slk_pkg::CMD_LOOKUP) && !lk_bad;

    slk_ram #(
        .WIDTH(16),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ld_pos[AW-1:0]),
        .i_wdata(i_req.load_entry),
        .i_re   (ram_re),
        .i_raddr(lk_pos[AW-1:0]),
        .o_rdata(ram_entry)
    );

    logic        r_b_valid;
    logic        r_b_cmd;
    logic        r_b_bad;
    logic [15:0] r_b_pos;
    logic [10:0] r_b_neuron;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_cmd    <= i_req.cmd;
            r_b_bad    <= (i_req.cmd == slk_pkg::CMD_LOAD) ? ld_bad : lk_bad;
            r_b_pos    <= (i_req.cmd == slk_pkg::CMD_LOAD) ? ld_pos : lk_pos;
            r_b_neuron <= i_req.spike_key[10:0];
        end
    end

    // stage b: size selection, stride multiply, miss counting
    logic [2:0]  sel;
    logic [15:0] words;
    logic [16:0] stride;
    logic [1:0]  b_status;
    logic [31:0] r_miss;
    logic [31:0] n_miss;

    assign sel    = ram_entry[2:0];
    assign words  = (sel == 3'd0) ? 16'd0 : r_row_words[sel];
    assign stride = {1'b0, words} + HDR;

    always_comb begin
        if (r_b_cmd == slk_pkg::CMD_LOAD) begin
            b_status = r_b_bad ? slk_pkg::ST_RANGE : slk_pkg::ST_LOADED;
        end else if (r_b_bad) begin
            b_status = slk_pkg::ST_RANGE;
        end else if (sel == 3'd0) begin
            b_status = slk_pkg::ST_MISS;
        end else begin
            b_status = slk_pkg::ST_HIT;
        end
    end

    assign n_miss = (r_b_valid && b_status == slk_pkg::ST_MISS) ? r_miss + 32'd1 : r_miss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miss <= '0;
        end else if (en) begin
            r_miss <= n_miss;
        end
    end

    logic        r_c_valid;
    logic [1:0]  r_c_status;
    logic [15:0] r_c_pos;
    logic [12:0] r_c_offset;
    logic [27:0] r_c_prod;
    logic [16:0] r_c_stride;
    logic [31:0] r_c_miss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_b_valid) begin
            r_c_status <= b_status;
            r_c_pos    <= r_b_pos;
            r_c_offset <= ram_entry[15:3];
            r_c_prod   <= {17'b0, r_b_neuron} * {11'b0, stride};
            r_c_stride <= stride;
            r_c_miss   <= n_miss;
        end
    end

    // stage c: row address sum
    slk_pkg::t_rsp c_rsp;
    slk_pkg::t_rsp r_out;

    always_comb begin
        c_rsp.status         = r_c_status;
        c_rsp.tbl_pos        = r_c_pos;
        c_rsp.miss_count     = r_c_miss;
        c_rsp.row_addr       = '0;
        c_rsp.transfer_bytes = '0;
        if (r_c_status == slk_pkg::ST_HIT) begin
            c_rsp.row_addr       = r_base + {9'b0, r_c_offset, 10'b0}
                                 + {2'b00, r_c_prod, 2'b00};
            c_rsp.transfer_bytes = {r_c_stride, 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_c_valid) begin
            r_out <= c_rsp;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

`ifndef SYNTHESIS
    // a load and a lookup never share the table in one cycle
    a_ram_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("table written and read in the same cycle");

    // miss counter only steps by one
    a_miss_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_miss != $past(r_miss)) |-> r_miss == $past(r_miss) + 32'd1)
        else $error("miss counter jumped");

    // address and size are zero unless the request hit
    a_nonhit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != slk_pkg::ST_HIT)
            |-> (r_out.row_addr == 32'd0 && r_out.transfer_bytes == 19'd0))
        else $error("non-hit result carries an address");

    // the sender is held off only by a pending result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_out_valid && i_stall))
        else $error("stall without a held result");
`endif

endmodule

// ----- hdl/slk_ram.sv -----
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module slk_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 1152,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
